// File: rtl/trc_pkg.sv
// Shared types, codes and helper functions for the TTL result cache.
// Used by trc_slot_mem, ttl_result_cache_top and trc_checker; depends on nothing.
package trc_pkg;

    localparam int SLOTS_DEFAULT = 256;
    localparam int CAP_W         = 8;
    localparam int GROUP_W       = 8;
    localparam int LIFE_W        = 24;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;
    localparam int CLASS_W       = 15;
    localparam int MIN_CAP       = 64;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [3:0] EV_FOOTSTEP = 4'd1;
    localparam logic [3:0] EV_SWING    = 4'd2;
    localparam logic [3:0] EV_IMPACT   = 4'd3;
    localparam logic [3:0] EV_JUMP     = 4'd4;
    localparam logic [3:0] EV_LAND     = 4'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOT_GROUP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFE_FOOT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFE_SWING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFE_IMP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFE_JUMP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFE_DEF   = 3'd6;

    typedef struct packed {
        logic [CAP_W-1:0]   capacity;
        logic [GROUP_W-1:0] footstep_group;
        logic [LIFE_W-1:0]  life_footstep;
        logic [LIFE_W-1:0]  life_swing;
        logic [LIFE_W-1:0]  life_impact;
        logic [LIFE_W-1:0]  life_jump_land;
        logic [LIFE_W-1:0]  life_default;
    } cfg_t;

    typedef struct packed {
        logic [63:0]        ids;
        logic [CLASS_W-1:0] cls;
        logic [63:0]        stamp;
        logic [63:0]        data;
    } entry_t;

    function automatic logic [LIFE_W-1:0] life_of(input cfg_t c, input logic [3:0] t);
        logic [LIFE_W-1:0] l;
        unique case (t)
            EV_FOOTSTEP:     l = c.life_footstep;
            EV_SWING:        l = c.life_swing;
            EV_IMPACT:       l = c.life_impact;
            EV_JUMP, EV_LAND: l = c.life_jump_land;
            default:         l = c.life_default;
        endcase
        return l;
    endfunction

    function automatic logic too_old(input logic [63:0] now, input logic [63:0] stamp,
                                     input logic [LIFE_W-1:0] life);
        logic [63:0] age;
        age = now - stamp;
        return (now > stamp) && (age > {{(64-LIFE_W){1'b0}}, life});
    endfunction

endpackage

// File: rtl/trc_slot_mem.sv
// Slot storage of the TTL result cache: key, class, stamp and payload per slot.
// One write port and one registered read port; uses trc_pkg.
module trc_slot_mem
    import trc_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT,
    parameter int AW    = $clog2(SLOTS)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_entry,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_entry
);

    entry_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_entry <= mem[rd_addr];
    end

endmodule

// File: rtl/ttl_result_cache_top.sv
// Each request other than a no-op runs an expiry sweep, then one more sweep for
// each entry evicted over capacity; a clear then empties the cache, and a lookup
// or store runs a further sweep for the key search and update. A no-op goes
// straight to its result. Every sweep walks the slot memory through its single
// read port, one slot a cycle, and the block takes no new request until the
// result has been loaded into the output register. Configuration may be written
// any time the block is idle. Top level; uses trc_pkg and trc_slot_mem.
module ttl_result_cache_top
    import trc_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           op,
    input  logic [3:0]           event_type,
    input  logic [7:0]           semantic_group,
    input  logic [31:0]          actor_id,
    input  logic [31:0]          form_id,
    input  logic [7:0]           intensity,
    input  logic [63:0]          now_us,
    input  logic [63:0]          payload,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit,
    output logic [63:0]          payload_out,
    output logic [63:0]          stamp_out
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int XW = (CW > CAP_W) ? CW : CAP_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PRUNE  = 3'd1;
    localparam logic [2:0] S_EVCHK  = 3'd2;
    localparam logic [2:0] S_EVICT  = 3'd3;
    localparam logic [2:0] S_EVDROP = 3'd4;
    localparam logic [2:0] S_FIND   = 3'd5;
    localparam logic [2:0] S_ACT    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    cfg_t cfg_reg;

    logic [2:0]         state_reg, state_next;
    logic [SLOTS-1:0]   valid_reg, valid_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW:0]        cnt_reg, cnt_next;
    logic               pv_reg, pv_next;
    logic [AW-1:0]      pidx_reg, pidx_next;

    logic [1:0]         op_reg;
    logic [63:0]        ids_reg;
    logic [CLASS_W-1:0] cls_reg;
    logic [63:0]        now_reg;
    logic [63:0]        data_reg;

    logic               best_found_reg, best_found_next;
    logic [AW-1:0]      best_idx_reg, best_idx_next;
    logic [63:0]        best_time_reg, best_time_next;
    logic               match_reg, match_next;
    logic [AW-1:0]      midx_reg, midx_next;
    logic [63:0]        mtime_reg, mtime_next;
    logic [63:0]        mdata_reg, mdata_next;
    logic               free_reg, free_next;
    logic [AW-1:0]      fidx_reg, fidx_next;

    logic               res_hit_reg, res_hit_next;
    logic [63:0]        res_data_reg, res_data_next;
    logic [63:0]        res_stamp_reg, res_stamp_next;

    logic               out_valid_reg, out_valid_next;
    logic               hit_reg;
    logic [63:0]        payload_out_reg;
    logic [63:0]        stamp_out_reg;

    entry_t             rd_entry;
    entry_t             wr_entry;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;

    logic               accept;
    logic               last;
    logic               slot_live;
    logic [CW-1:0]      cap_eff;
    logic [XW-1:0]      cap_x;
    logic               load_out;

    // Key folding and intensity bucket for the incoming request.
    logic [7:0]         k_group;
    logic [31:0]        k_actor;
    logic [31:0]        k_form;
    logic [2:0]         k_bucket;

    always_comb
    begin
        k_group  = semantic_group;
        k_actor  = actor_id;
        k_form   = form_id;
        k_bucket = intensity[7:5];
        if (event_type == EV_JUMP || event_type == EV_LAND)
        begin
            k_group  = cfg_reg.footstep_group;
            k_actor  = '0;
            k_form   = '0;
            k_bucket = '0;
        end
        else if (event_type == EV_FOOTSTEP)
        begin
            k_group  = cfg_reg.footstep_group;
            k_form   = '0;
            k_bucket = {1'b0, intensity[7:6]};
        end
    end

    always_comb
    begin
        cap_x = XW'(cfg_reg.capacity);
        if (cap_x < XW'(MIN_CAP))
        begin
            cap_x = XW'(MIN_CAP);
        end
        if (cap_x > XW'(SLOTS - 1))
        begin
            cap_x = XW'(SLOTS - 1);
        end
        cap_eff = CW'(cap_x);
    end

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign last      = pv_reg && (pidx_reg == AW'(SLOTS - 1));
    assign slot_live = pv_reg && valid_reg[pidx_reg];
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign wr_entry.ids   = ids_reg;
    assign wr_entry.cls   = cls_reg;
    assign wr_entry.stamp = now_reg;
    assign wr_entry.data  = data_reg;

    trc_slot_mem #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_mem (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_addr  (cnt_reg[AW-1:0]),
        .rd_entry (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capacity       <= 8'd255;
            cfg_reg.footstep_group <= 8'd1;
            cfg_reg.life_footstep  <= 24'd300000;
            cfg_reg.life_swing     <= 24'd220000;
            cfg_reg.life_impact    <= 24'd180000;
            cfg_reg.life_jump_land <= 24'd900000;
            cfg_reg.life_default   <= 24'd160000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAPACITY:   cfg_reg.capacity       <= cfg_data[CAP_W-1:0];
                CFG_FOOT_GROUP: cfg_reg.footstep_group <= cfg_data[GROUP_W-1:0];
                CFG_LIFE_FOOT:  cfg_reg.life_footstep  <= cfg_data;
                CFG_LIFE_SWING: cfg_reg.life_swing     <= cfg_data;
                CFG_LIFE_IMP:   cfg_reg.life_impact    <= cfg_data;
                CFG_LIFE_JUMP:  cfg_reg.life_jump_land <= cfg_data;
                CFG_LIFE_DEF:   cfg_reg.life_default   <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        cnt_next        = cnt_reg;
        pv_next         = 1'b0;
        pidx_next       = cnt_reg[AW-1:0];
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_time_next  = best_time_reg;
        match_next      = match_reg;
        midx_next       = midx_reg;
        mtime_next      = mtime_reg;
        mdata_next      = mdata_reg;
        free_next       = free_reg;
        fidx_next       = fidx_reg;
        res_hit_next    = res_hit_reg;
        res_data_next   = res_data_reg;
        res_stamp_next  = res_stamp_reg;
        wr_en           = 1'b0;
        wr_addr         = midx_reg;

        // Sweep states issue one slot read a cycle; the data is handled in the next cycle.
        if ((state_reg == S_PRUNE || state_reg == S_EVICT || state_reg == S_FIND)
            && (cnt_reg < (AW+1)'(SLOTS)))
        begin
            pv_next  = 1'b1;
            cnt_next = cnt_reg + 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_hit_next   = 1'b0;
                    res_data_next  = '0;
                    res_stamp_next = '0;
                    cnt_next       = '0;
                    state_next     = (op == OP_NONE) ? S_DONE : S_PRUNE;
                end
            end
            S_PRUNE:
            begin
                if (slot_live && too_old(now_reg, rd_entry.stamp,
                                         life_of(cfg_reg, rd_entry.cls[3:0])))
                begin
                    valid_next[pidx_reg] = 1'b0;
                    count_next           = count_reg - 1'b1;
                end
                if (last)
                begin
                    state_next = S_EVCHK;
                end
            end
            S_EVCHK:
            begin
                cnt_next        = '0;
                best_found_next = 1'b0;
                match_next      = 1'b0;
                free_next       = 1'b0;
                if (count_reg > cap_eff)
                begin
                    state_next = S_EVICT;
                end
                else if (op_reg == OP_CLEAR)
                begin
                    valid_next = '0;
                    count_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FIND;
                end
            end
            S_EVICT:
            begin
                if (slot_live && (!best_found_reg || rd_entry.stamp < best_time_reg))
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = pidx_reg;
                    best_time_next  = rd_entry.stamp;
                end
                if (last)
                begin
                    state_next = S_EVDROP;
                end
            end
            S_EVDROP:
            begin
                if (best_found_reg)
                begin
                    valid_next[best_idx_reg] = 1'b0;
                    count_next               = count_reg - 1'b1;
                end
                state_next = S_EVCHK;
            end
            S_FIND:
            begin
                if (slot_live && !match_reg && rd_entry.ids == ids_reg
                    && rd_entry.cls == cls_reg)
                begin
                    match_next = 1'b1;
                    midx_next  = pidx_reg;
                    mtime_next = rd_entry.stamp;
                    mdata_next = rd_entry.data;
                end
                if (pv_reg && !valid_reg[pidx_reg] && !free_reg)
                begin
                    free_next = 1'b1;
                    fidx_next = pidx_reg;
                end
                if (last)
                begin
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                state_next = S_DONE;
                if (op_reg == OP_LOOKUP)
                begin
                    if (match_reg)
                    begin
                        // A stamp not older than now, or already expired, is erased.
                        if (now_reg <= mtime_reg
                            || too_old(now_reg, mtime_reg, life_of(cfg_reg, cls_reg[3:0])))
                        begin
                            valid_next[midx_reg] = 1'b0;
                            count_next           = count_reg - 1'b1;
                        end
                        else
                        begin
                            res_hit_next   = 1'b1;
                            res_data_next  = mdata_reg;
                            res_stamp_next = now_reg;
                        end
                    end
                end
                else if (match_reg)
                begin
                    wr_en = 1'b1;
                end
                else if (free_reg)
                begin
                    wr_en                = 1'b1;
                    wr_addr              = fidx_reg;
                    valid_next[fidx_reg] = 1'b1;
                    count_next           = count_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            count_reg      <= '0;
            cnt_reg        <= '0;
            pv_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            match_reg      <= 1'b0;
            free_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            cnt_reg        <= cnt_next;
            pv_reg         <= pv_next;
            out_valid_reg  <= out_valid_next;
            best_found_reg <= best_found_next;
            match_reg      <= match_next;
            free_reg       <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg      <= pidx_next;
        best_idx_reg  <= best_idx_next;
        best_time_reg <= best_time_next;
        midx_reg      <= midx_next;
        mtime_reg     <= mtime_next;
        mdata_reg     <= mdata_next;
        fidx_reg      <= fidx_next;
        res_hit_reg   <= res_hit_next;
        res_data_reg  <= res_data_next;
        res_stamp_reg <= res_stamp_next;
        if (accept)
        begin
            op_reg   <= op;
            ids_reg  <= {k_actor, k_form};
            cls_reg  <= {k_bucket, k_group, event_type};
            now_reg  <= now_us;
            data_reg <= payload;
        end
        if (load_out)
        begin
            hit_reg         <= res_hit_reg;
            payload_out_reg <= res_data_reg;
            stamp_out_reg   <= res_stamp_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign payload_out = payload_out_reg;
    assign stamp_out   = stamp_out_reg;

endmodule

// File: rtl/trc_checker.sv
// Port-level checks for the TTL result cache, bound to ttl_result_cache_top.
// Imports trc_pkg; its ports take no widths from it.
module trc_checker
    import trc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        hit,
    input logic [63:0] payload_out,
    input logic [63:0] stamp_out
);

    // A request is followed by busy cycles: no request, not even a no-op, completes at once.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while not busy afterwards");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(payload_out) && $stable(hit))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> payload_out == 64'd0 && stamp_out == 64'd0)
        else $error("miss with non-zero fields");

    // A hit needs now strictly newer than a stored stamp, so now is never zero.
    a_hit_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> stamp_out != 64'd0)
        else $error("hit with zero stamp");

endmodule

bind ttl_result_cache_top trc_checker u_trc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .payload_out (payload_out),
    .stamp_out   (stamp_out)
);

// File: sim/ttl_result_cache_top_tb.sv
// Self-checking testbench for ttl_result_cache_top: drives lookup, store and clear
// requests, predicts each result with its own cache model and checks it field by field.
// Depends on trc_pkg and the ttl_result_cache_top RTL only.
module ttl_result_cache_top_tb;
    import trc_pkg::*;

    localparam int NSLOT = 256;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  etype;
        logic [7:0]  group;
        logic [31:0] actor;
        logic [31:0] form;
        logic [7:0]  inten;
        logic [63:0] now;
        logic [63:0] pay;
    } request_t;

    typedef struct packed {
        logic        hit;
        logic [63:0] pay;
        logic [63:0] stamp;
    } answer_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            op;
    logic [3:0]            event_type;
    logic [7:0]            semantic_group;
    logic [31:0]           actor_id;
    logic [31:0]           form_id;
    logic [7:0]            intensity;
    logic [63:0]           now_us;
    logic [63:0]           payload;
    logic                  out_valid;
    logic                  out_stall;
    logic                  hit;
    logic [63:0]           payload_out;
    logic [63:0]           stamp_out;

    // Cache model state and its copy of the registers.
    logic [7:0]  m_capacity;
    logic [7:0]  m_foot_group;
    logic [23:0] m_life_foot, m_life_swing, m_life_impact, m_life_jump, m_life_def;
    bit          m_valid [NSLOT];
    logic [63:0] m_ids   [NSLOT];
    logic [14:0] m_cls   [NSLOT];
    logic [63:0] m_stamp [NSLOT];
    logic [63:0] m_data  [NSLOT];
    int          m_live;

    answer_t     pending_answers[$];
    request_t    recent_stores[$];
    logic [63:0] clock_us;
    int          errors;
    int          requests_sent;
    int          answers_checked;
    int          hits_seen;
    int          evictions;
    int          hold_left;
    bit          quiet_tx;
    bit          quiet_rx;

    ttl_result_cache_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .event_type(event_type), .semantic_group(semantic_group),
        .actor_id(actor_id), .form_id(form_id), .intensity(intensity),
        .now_us(now_us), .payload(payload),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .payload_out(payload_out), .stamp_out(stamp_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #80_000_000;
        $display("FAIL");
        $finish;
    end

    // ---------------- cache model ----------------

    function automatic logic [23:0] lifetime_for(logic [3:0] t);
        logic [23:0] l;
        case (t)
            EV_FOOTSTEP:      l = m_life_foot;
            EV_SWING:         l = m_life_swing;
            EV_IMPACT:        l = m_life_impact;
            EV_JUMP, EV_LAND: l = m_life_jump;
            default:          l = m_life_def;
        endcase
        return l;
    endfunction

    function automatic bit expired(logic [63:0] now, logic [63:0] stamp, logic [3:0] t);
        return (now > stamp) && ((now - stamp) > {40'd0, lifetime_for(t)});
    endfunction

    function automatic void drop_slot(int s);
        m_valid[s] = 0;
        m_live--;
    endfunction

    function automatic void prune_cache(logic [63:0] now);
        int limit;
        int oldest;
        limit = (m_capacity < MIN_CAP) ? MIN_CAP : int'(m_capacity);
        if (limit > NSLOT - 1)
            limit = NSLOT - 1;
        for (int s = 0; s < NSLOT; s++)
            if (m_valid[s] && expired(now, m_stamp[s], m_cls[s][3:0]))
                drop_slot(s);
        while (m_live > limit)
        begin
            oldest = -1;
            for (int s = 0; s < NSLOT; s++)
                if (m_valid[s] && (oldest < 0 || m_stamp[s] < m_stamp[oldest]))
                    oldest = s;
            drop_slot(oldest);
            evictions++;
        end
    endfunction

    function automatic answer_t predict_answer(request_t r);
        answer_t     a;
        logic [7:0]  grp;
        logic [31:0] act, frm;
        logic [2:0]  bucket;
        logic [63:0] key_ids;
        logic [14:0] key_cls;
        int          found;
        a = '0;
        if (r.op == OP_NONE)
            return a;
        prune_cache(r.now);
        if (r.op == OP_CLEAR)
        begin
            for (int s = 0; s < NSLOT; s++)
                m_valid[s] = 0;
            m_live = 0;
            return a;
        end
        grp = r.group;
        act = r.actor;
        frm = r.form;
        bucket = r.inten[7:5];
        if (r.etype == EV_JUMP || r.etype == EV_LAND)
        begin
            grp = m_foot_group;
            act = '0;
            frm = '0;
            bucket = '0;
        end
        else if (r.etype == EV_FOOTSTEP)
        begin
            grp = m_foot_group;
            frm = '0;
            bucket = {1'b0, r.inten[7:6]};
        end
        key_ids = {act, frm};
        key_cls = {bucket, grp, r.etype};
        found = -1;
        for (int s = 0; s < NSLOT; s++)
            if (found < 0 && m_valid[s] && m_ids[s] == key_ids && m_cls[s] == key_cls)
                found = s;
        if (r.op == OP_LOOKUP)
        begin
            if (found < 0)
                return a;
            // A stamp that is not strictly in the past counts as stale.
            if (r.now <= m_stamp[found] || expired(r.now, m_stamp[found], r.etype))
            begin
                drop_slot(found);
                return a;
            end
            a.hit = 1'b1;
            a.pay = m_data[found];
            a.stamp = r.now;
            return a;
        end
        if (found < 0)
        begin
            for (int s = 0; s < NSLOT; s++)
                if (found < 0 && !m_valid[s])
                    found = s;
            if (found < 0)
                return a;
            m_valid[found] = 1;
            m_live++;
        end
        m_ids[found] = key_ids;
        m_cls[found] = key_cls;
        m_stamp[found] = r.now;
        m_data[found] = r.pay;
        return a;
    endfunction

    // ---------------- drivers ----------------

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_tx || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    task automatic send_request(request_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        op             <= r.op;
        event_type     <= r.etype;
        semantic_group <= r.group;
        actor_id       <= r.actor;
        form_id        <= r.form;
        intensity      <= r.inten;
        now_us         <= r.now;
        payload        <= r.pay;
        do
            @(posedge clk);
        while (in_stall);
        pending_answers.push_back(predict_answer(r));
        requests_sent++;
        if (r.op == OP_STORE)
        begin
            recent_stores.push_back(r);
            if (recent_stores.size() > 40)
                void'(recent_stores.pop_front());
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_answers.size() > 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // The enable drops right after the edge that writes the register, and stays low until the task returns.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CAPACITY:   m_capacity   = value[7:0];
            CFG_FOOT_GROUP: m_foot_group = value[7:0];
            CFG_LIFE_FOOT:  m_life_foot  = value;
            CFG_LIFE_SWING: m_life_swing = value;
            CFG_LIFE_IMP:   m_life_impact = value;
            CFG_LIFE_JUMP:  m_life_jump  = value;
            CFG_LIFE_DEF:   m_life_def   = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_lifetimes(logic [23:0] foot, logic [23:0] swing, logic [23:0] imp,
                                   logic [23:0] jump, logic [23:0] other);
        write_reg(CFG_LIFE_FOOT, foot);
        write_reg(CFG_LIFE_SWING, swing);
        write_reg(CFG_LIFE_IMP, imp);
        write_reg(CFG_LIFE_JUMP, jump);
        write_reg(CFG_LIFE_DEF, other);
    endtask

    function automatic logic [31:0] pick_id();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0011;
            3: return 32'h8000_0000;
            4, 5: return $urandom();
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    function automatic request_t make_request(int store_pct, int max_step);
        request_t r;
        int       roll;
        r.etype = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(1, 5));
        r.group = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 2));
        r.actor = pick_id();
        r.form  = pick_id();
        r.inten = 8'($urandom_range(0, 255));
        r.pay   = {$urandom(), $urandom()};
        roll = $urandom_range(0, 99);
        if (roll < store_pct)
            r.op = OP_STORE;
        else if (roll < 96)
            r.op = OP_LOOKUP;
        else if (roll < 98)
            r.op = OP_CLEAR;
        else
            r.op = OP_NONE;
        // Most lookups reuse the event, group and ids of a recent store.
        if (r.op == OP_LOOKUP && recent_stores.size() > 0 && $urandom_range(0, 9) < 7)
        begin
            request_t old;
            old = recent_stores[$urandom_range(0, recent_stores.size() - 1)];
            r.etype = old.etype;
            r.group = old.group;
            r.actor = old.actor;
            r.form  = old.form;
            r.inten = ($urandom_range(0, 1) == 0) ? old.inten : 8'($urandom_range(0, 255));
        end
        roll = $urandom_range(0, 99);
        if (roll < 8)
            ;
        else if (roll < 94)
            clock_us = clock_us + $urandom_range(1, max_step);
        else if (roll < 97)
            clock_us = clock_us + $urandom_range(500_000, 20_000_000);
        else if (roll < 99)
            clock_us = clock_us - $urandom_range(1, 200_000);
        else
            clock_us = {$urandom(), $urandom()};
        r.now = clock_us;
        return r;
    endfunction

    function automatic request_t keyed(logic [1:0] o, logic [3:0] t, logic [7:0] g,
                                       logic [31:0] a, logic [31:0] f, logic [7:0] i,
                                       logic [63:0] now, logic [63:0] p);
        request_t r;
        r = '{op: o, etype: t, group: g, actor: a, form: f, inten: i, now: now, pay: p};
        return r;
    endfunction

    // ---------------- result checking ----------------

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch in %s at %0t: got %h, expected %h", what, $time, got, want);
    endtask

    initial
    begin
        int stall_left;
        answer_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_answers.size() == 0)
                    report_mismatch("unexpected result", {63'd0, hit}, 64'd0);
                else
                begin
                    want = pending_answers.pop_front();
                    answers_checked++;
                    if (hit)
                        hits_seen++;
                    if (hit !== want.hit)
                        report_mismatch("hit", {63'd0, hit}, {63'd0, want.hit});
                    if (payload_out !== want.pay)
                        report_mismatch("payload_out", payload_out, want.pay);
                    if (stamp_out !== want.stamp)
                        report_mismatch("stamp_out", stamp_out, want.stamp);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!quiet_rx && $urandom_range(0, 7) == 0)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 400)
                                                             : $urandom_range(1, 4);
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_key_folding();
        send_request(keyed(OP_STORE, EV_FOOTSTEP, 8'h55, 32'h1, 32'hAAAA_AAAA, 8'h00, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF));
        // Same time as the store, so the entry is not strictly older: miss.
        send_request(keyed(OP_LOOKUP, EV_FOOTSTEP, 8'h55, 32'h1, 32'h0, 8'h3F, 64'd0, '0));
        send_request(keyed(OP_STORE, EV_FOOTSTEP, 8'h00, 32'h1, 32'h0, 8'hC0, 64'd10, 64'h0123_4567_89AB_CDEF));
        // Group and form are folded away for footsteps, so this hits.
        send_request(keyed(OP_LOOKUP, EV_FOOTSTEP, 8'hFF, 32'h1, 32'hFFFF_FFFF, 8'hFF, 64'd20, '0));
        send_request(keyed(OP_LOOKUP, EV_FOOTSTEP, 8'hFF, 32'h1, 32'h0, 8'h80, 64'd21, '0));
        send_request(keyed(OP_STORE, EV_JUMP, 8'h12, 32'hDEAD_BEEF, 32'h1234, 8'hFF, 64'd30, 64'h1));
        send_request(keyed(OP_LOOKUP, EV_JUMP, 8'h00, 32'h0, 32'hFFFF_FFFF, 8'h00, 64'd31, '0));
        send_request(keyed(OP_LOOKUP, EV_LAND, 8'h00, 32'h0, 32'h0, 8'h00, 64'd32, '0));
        send_request(keyed(OP_STORE, EV_LAND, 8'hFF, 32'hFFFF_FFFF, 32'h0, 8'h7F, 64'd33, 64'h2));
        send_request(keyed(OP_LOOKUP, EV_LAND, 8'h01, 32'h5, 32'h6, 8'hE0, 64'd40, '0));
        send_request(keyed(OP_STORE, EV_SWING, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 64'd50, 64'h3));
        send_request(keyed(OP_LOOKUP, EV_SWING, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hE0, 64'd60, '0));
        send_request(keyed(OP_LOOKUP, EV_SWING, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hDF, 64'd61, '0));
        send_request(keyed(OP_STORE, EV_IMPACT, 8'h0, 32'h0, 32'h0, 8'h00, 64'd70, 64'h4));
        send_request(keyed(OP_STORE, 4'd0, 8'h7, 32'h7, 32'h7, 8'h20, 64'd71, 64'h5));
        send_request(keyed(OP_STORE, 4'd15, 8'h7, 32'h7, 32'h7, 8'h20, 64'd72, 64'h6));
        send_request(keyed(OP_NONE, 4'd15, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, '1, '1));
        // Lifetime of impact entries runs out; swing entry still lives.
        send_request(keyed(OP_LOOKUP, EV_IMPACT, 8'h0, 32'h0, 32'h0, 8'h00, 64'd180_071, '0));
        send_request(keyed(OP_LOOKUP, 4'd15, 8'h7, 32'h7, 32'h7, 8'h3F, 64'd100_000, '0));
        send_request(keyed(OP_CLEAR, 4'd0, 8'h0, 32'h0, 32'h0, 8'h0, 64'd100_001, '0));
        send_request(keyed(OP_LOOKUP, 4'd0, 8'h7, 32'h7, 32'h7, 8'h20, 64'd100_002, '0));
        send_request(keyed(OP_STORE, 4'd9, 8'h9, 32'h9, 32'h9, 8'h9, '1, 64'h7));
        send_request(keyed(OP_LOOKUP, 4'd9, 8'h9, 32'h9, 32'h9, 8'h9, '1, '0));
        send_request(keyed(OP_CLEAR, 4'd0, 8'h0, 32'h0, 32'h0, 8'h0, '1, '0));
        wait_idle();
    endtask

    task automatic test_short_lifetimes();
        write_lifetimes(24'd0, 24'd1, 24'd5, 24'hFFFFFF, 24'd3);
        write_reg(CFG_FOOT_GROUP, 24'hFF);
        clock_us = 64'd1000;
        repeat (40)
            send_request(make_request(50, 4));
        wait_idle();
    endtask

    task automatic test_capacity_eviction();
        write_lifetimes('1, '1, '1, '1, '1);
        // Zero is below the minimum and behaves as 64.
        write_reg(CFG_CAPACITY, 24'd0);
        clock_us = 64'd5_000_000;
        repeat (90)
            send_request(make_request(90, 3));
        wait_idle();
        write_reg(CFG_CAPACITY, 24'd255);
        repeat (270)
            send_request(make_request(92, 2));
        wait_idle();
        // Dropping the capacity makes the next request evict many entries.
        write_reg(CFG_CAPACITY, 24'd64);
        repeat (20)
            send_request(make_request(60, 2));
        wait_idle();
    endtask

    task automatic test_backpressure();
        write_reg(CFG_CAPACITY, 24'd200);
        hold_left = 3000;
        quiet_tx = 1;
        repeat (12)
            send_request(make_request(50, 20_000));
        quiet_tx = 0;
        // Sender waits for every outstanding result before going on.
        wait_idle();
        quiet_rx = 1;
        repeat (20)
            send_request(make_request(50, 20_000));
        quiet_rx = 0;
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_CAPACITY, 24'd255);
                    write_reg(CFG_FOOT_GROUP, 24'd1);
                    write_lifetimes(24'd300_000, 24'd220_000, 24'd180_000, 24'd900_000,
                                    24'd160_000);
                end
                1:
                begin
                    write_reg(CFG_CAPACITY, 24'($urandom_range(64, 255)));
                    write_reg(CFG_FOOT_GROUP, 24'($urandom_range(0, 255)));
                    write_lifetimes(24'($urandom_range(0, 24'hFFFFFF)),
                                    24'($urandom_range(0, 500_000)),
                                    24'($urandom_range(0, 500_000)),
                                    24'($urandom_range(0, 2_000_000)),
                                    24'($urandom_range(0, 24'hFFFFFF)));
                end
                2:
                begin
                    write_reg(CFG_CAPACITY, 24'd64);
                    write_reg(CFG_FOOT_GROUP, 24'd0);
                    write_lifetimes('1, '1, 24'd0, '1, '1);
                end
                default:
                begin
                    write_reg(CFG_CAPACITY, 24'd100);
                    write_reg(CFG_FOOT_GROUP, 24'd2);
                    write_lifetimes(24'd60_000, 24'd40_000, 24'd20_000, 24'd100_000,
                                    24'd30_000);
                end
            endcase
            quiet_tx = (phase == 3);
            repeat (170)
                send_request(make_request(45, 60_000));
            quiet_tx = 0;
            wait_idle();
        end
    endtask

    initial
    begin
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        out_stall <= 1'b0;
        op <= OP_LOOKUP;
        event_type <= '0;
        semantic_group <= '0;
        actor_id <= '0;
        form_id <= '0;
        intensity <= '0;
        now_us <= '0;
        payload <= '0;
        rst_n = 1'b0;
        errors = 0;
        requests_sent = 0;
        answers_checked = 0;
        hits_seen = 0;
        evictions = 0;
        hold_left = 0;
        quiet_tx = 0;
        quiet_rx = 0;
        clock_us = '0;
        m_capacity = 8'd255;
        m_foot_group = 8'd1;
        m_life_foot = 24'd300_000;
        m_life_swing = 24'd220_000;
        m_life_impact = 24'd180_000;
        m_life_jump = 24'd900_000;
        m_life_def = 24'd160_000;
        m_live = 0;
        for (int s = 0; s < NSLOT; s++)
            m_valid[s] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_key_folding();
        test_short_lifetimes();
        test_capacity_eviction();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (600) @(posedge clk);
        $display("Sent %0d requests and checked %0d results, %0d of them hits.",
                 requests_sent, answers_checked, hits_seen);
        $display("The model evicted %0d entries over capacity across all register settings.",
                 evictions);
        if (errors == 0 && pending_answers.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
